/* rtl/core/assert_macros.svh */
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define RFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define RFC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/core/rfc_pkg.sv */
package rfc_pkg;

  // configuration register map, one 32-bit register every 4 bytes
  typedef enum logic [2:0] {
    CFG_ORIGIN_X,
    CFG_ORIGIN_Y,
    CFG_ORIGIN_Z,
    CFG_QUAT_W,
    CFG_QUAT_X,
    CFG_QUAT_Y,
    CFG_QUAT_Z
  } cfg_reg_e;

  localparam int unsigned NUM_CFG     = 7;
  // normalized magnitudes sit in [2^30, 2^31)
  localparam int unsigned NORM_MSB    = 30;
  // one root bit per stage for a 64-bit radicand
  localparam int unsigned SQRT_STAGES = 32;

  typedef struct packed {
    logic signed [31:0] child_origin_x;
    logic signed [31:0] child_origin_y;
    logic signed [31:0] child_origin_z;
    logic signed [31:0] child_quat_w;
    logic signed [31:0] child_quat_x;
    logic signed [31:0] child_quat_y;
    logic signed [31:0] child_quat_z;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_origin_x;
    logic signed [31:0] out_origin_y;
    logic signed [31:0] out_origin_z;
    logic signed [31:0] out_quat_w;
    logic signed [31:0] out_quat_x;
    logic signed [31:0] out_quat_y;
    logic signed [31:0] out_quat_z;
    logic               saturated;
  } out_t;

  // sideband that rides along the quaternion normalization stages
  typedef struct packed {
    logic [2:0][31:0] rot;
    logic             sat;
    logic [3:0]       neg;
    logic             zero;
  } side_t;

endpackage

/* rtl/core/rfc_in_if.sv */
interface rfc_in_if;
  logic          valid;
  logic          ready;
  rfc_pkg::in_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/rfc_out_if.sv */
interface rfc_out_if;
  logic          valid;
  logic          ready;
  rfc_pkg::out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/rigid_frame_compose.sv */
// rigid frame composition: puts a child pose (translation, quaternion, per-axis
// scale) on the in_i channel and returns the composed pose on out_o, one word out
// for every word in. the parent pose sits in seven apb registers (origin x/y/z,
// quaternion w/x/y/z at byte offsets 0..24); write them only while the block is
// empty. after a register write the parent rotation matrix is rebuilt through the
// product registers and then the sum registers. from accept to out_o.valid a word
// passes eight arithmetic stages, 32 stages of the bit-serial square root and
// QUAT_FRAC_BITS + 1 stages of the restoring dividers that scale the quaternion.
// throughput: one word per cycle outside stalls, set by the fully pipelined root and dividers.
// reset (rst_ni low, async) empties the pipeline and loads the identity parent.
// when the receiver stalls, the result stays in the output register and one more
// word lands in a skid register; only then does the whole pipeline freeze and
// in_i.ready drop. nothing is lost or repeated across a stall.
`include "assert_macros.svh"

module rigid_frame_compose #(
  parameter int unsigned POS_FRAC_BITS  = 16,
  parameter int unsigned QUAT_FRAC_BITS = 30
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rfc_in_if.sink      in_i,
  rfc_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic signed [63:0] QOne  = 64'sd1 <<< QUAT_FRAC_BITS;
  localparam logic signed [63:0] QOne2 = 64'sd1 <<< (2 * QUAT_FRAC_BITS);
  localparam logic signed [63:0] QHalf = 64'sd1 <<< (QUAT_FRAC_BITS - 1);
  localparam logic signed [63:0] PHalf = 64'sd1 <<< (POS_FRAC_BITS - 1);
  localparam int unsigned        QuoW  = QUAT_FRAC_BITS + 1;
  localparam int unsigned        DivStages = QUAT_FRAC_BITS + 1;
  localparam int unsigned        SqStages  = rfc_pkg::SQRT_STAGES;

  // ---------------------------------------------------------------------------
  // helpers
  // ---------------------------------------------------------------------------
  function automatic logic signed [31:0] clamp_quat(input logic [31:0] v);
    logic signed [63:0] w;
    w = {{32{v[31]}}, v};
    if (w > QOne) begin
      clamp_quat = 32'(QOne);
    end else if (w < -QOne) begin
      clamp_quat = 32'(-QOne);
    end else begin
      clamp_quat = v;
    end
  endfunction

  // round half up to QUAT_FRAC_BITS, then clamp to [-1, +1]
  function automatic logic signed [31:0] mat_elem(input logic signed [63:0] wide);
    logic signed [63:0] r;
    r = (wide + QHalf) >>> QUAT_FRAC_BITS;
    if (r > QOne) begin
      mat_elem = 32'(QOne);
    end else if (r < -QOne) begin
      mat_elem = 32'(-QOne);
    end else begin
      mat_elem = 32'(r);
    end
  endfunction

  // {clipped, value}
  function automatic logic [32:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh7fff_ffff) begin
      sat32 = {1'b1, 32'h7fff_ffff};
    end else if (v < -64'sh8000_0000) begin
      sat32 = {1'b1, 32'h8000_0000};
    end else begin
      sat32 = {1'b0, v[31:0]};
    end
  endfunction

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  logic [31:0] cfg_q [rfc_pkg::NUM_CFG];
  logic [2:0]  cfg_idx;
  logic        cfg_wr;

  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rfc_pkg::NUM_CFG; i++) begin
        cfg_q[i] <= '0;
      end
      cfg_q[rfc_pkg::CFG_QUAT_W] <= 32'(QOne);
    end else if (cfg_wr && (32'(cfg_idx) < rfc_pkg::NUM_CFG)) begin
      cfg_q[cfg_idx] <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (32'(cfg_idx) < rfc_pkg::NUM_CFG) begin
      prdata = cfg_q[cfg_idx];
    end
  end

  // parent quaternion, clamped to [-1, +1]
  logic signed [31:0] pw, px, py, pz;
  assign pw = clamp_quat(cfg_q[rfc_pkg::CFG_QUAT_W]);
  assign px = clamp_quat(cfg_q[rfc_pkg::CFG_QUAT_X]);
  assign py = clamp_quat(cfg_q[rfc_pkg::CFG_QUAT_Y]);
  assign pz = clamp_quat(cfg_q[rfc_pkg::CFG_QUAT_Z]);

  // ---------------------------------------------------------------------------
  // rotation matrix: products, then sums / round / clamp (free running)
  // ---------------------------------------------------------------------------
  logic signed [63:0] mxx_q, myy_q, mzz_q, mxy_q, mxz_q, myz_q, mwx_q, mwy_q, mwz_q;
  logic signed [31:0] m_q [9];

  always_ff @(posedge clk_i) begin
    mxx_q <= px * px;
    myy_q <= py * py;
    mzz_q <= pz * pz;
    mxy_q <= px * py;
    mxz_q <= px * pz;
    myz_q <= py * pz;
    mwx_q <= pw * px;
    mwy_q <= pw * py;
    mwz_q <= pw * pz;
  end

  always_ff @(posedge clk_i) begin
    m_q[0] <= mat_elem(QOne2 - ((myy_q + mzz_q) <<< 1));
    m_q[1] <= mat_elem((mxy_q + mwz_q) <<< 1);
    m_q[2] <= mat_elem((mxz_q - mwy_q) <<< 1);
    m_q[3] <= mat_elem((mxy_q - mwz_q) <<< 1);
    m_q[4] <= mat_elem(QOne2 - ((mxx_q + mzz_q) <<< 1));
    m_q[5] <= mat_elem((myz_q + mwx_q) <<< 1);
    m_q[6] <= mat_elem((mxz_q + mwy_q) <<< 1);
    m_q[7] <= mat_elem((myz_q - mwx_q) <<< 1);
    m_q[8] <= mat_elem(QOne2 - ((mxx_q + myy_q) <<< 1));
  end

  // ---------------------------------------------------------------------------
  // pipeline control: the whole pipe moves unless the skid register is full
  // ---------------------------------------------------------------------------
  logic en;
  logic skid_v_q, out_v_q;
  logic in_acc;

  assign en         = ~skid_v_q;
  assign in_i.ready = en;
  assign in_acc     = in_i.valid & en;

  // ---------------------------------------------------------------------------
  // stage 1: scale products and quaternion partial products
  // ---------------------------------------------------------------------------
  logic                     v1_q;
  logic signed [63:0]       scp_q [3];
  logic signed [63:0]       qp_q [4][4];   // [parent][child]
  logic signed [31:0]       cq [4];
  logic signed [31:0]       pq [4];

  assign cq[0] = clamp_quat(in_i.data.child_quat_w);
  assign cq[1] = clamp_quat(in_i.data.child_quat_x);
  assign cq[2] = clamp_quat(in_i.data.child_quat_y);
  assign cq[3] = clamp_quat(in_i.data.child_quat_z);
  assign pq[0] = pw;
  assign pq[1] = px;
  assign pq[2] = py;
  assign pq[3] = pz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      scp_q[0] <= in_i.data.child_origin_x * in_i.data.scale_x;
      scp_q[1] <= in_i.data.child_origin_y * in_i.data.scale_y;
      scp_q[2] <= in_i.data.child_origin_z * in_i.data.scale_z;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          qp_q[i][j] <= pq[i] * cq[j];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: scaled translation, hamilton product sums
  // ---------------------------------------------------------------------------
  logic               v2_q, sf2_q;
  logic signed [31:0] s2_q [3];
  logic signed [63:0] q2_q [4];
  logic [32:0]        s2_sat [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s2_sat[i] = sat32((scp_q[i] + PHalf) >>> POS_FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_q[i] <= s2_sat[i][31:0];
      end
      sf2_q   <= s2_sat[0][32] | s2_sat[1][32] | s2_sat[2][32];
      q2_q[0] <= qp_q[0][0] - qp_q[1][1] - qp_q[2][2] - qp_q[3][3];
      q2_q[1] <= qp_q[1][0] + qp_q[0][1] + qp_q[2][3] - qp_q[3][2];
      q2_q[2] <= qp_q[0][2] - qp_q[1][3] + qp_q[2][0] + qp_q[3][1];
      q2_q[3] <= qp_q[1][2] + qp_q[0][3] - qp_q[2][1] + qp_q[3][0];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: rotate the scaled translation, split quaternion into sign/magnitude
  // ---------------------------------------------------------------------------
  logic               v3_q, sf3_q;
  logic signed [63:0] sm3_q [3][3];      // [axis][term]
  logic [62:0]        mag3_q [4];
  logic [3:0]         neg3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          sm3_q[i][k] <= s2_q[k] * m_q[3 * k + i];
        end
      end
      for (int i = 0; i < 4; i++) begin
        neg3_q[i] <= q2_q[i][63];
        mag3_q[i] <= q2_q[i][63] ? 63'(-q2_q[i]) : 63'(q2_q[i]);
      end
      sf3_q <= sf2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: final origin, leading-one search per byte of the magnitudes
  // ---------------------------------------------------------------------------
  logic              v4_q;
  rfc_pkg::side_t    side4_q;
  logic [62:0]       mag4_q [4];
  logic [7:0]        cnz4_q;
  logic [7:0][2:0]   cpos4_q;

  rfc_pkg::side_t    side4_d;
  logic [63:0]       or_word;
  logic [7:0]        cnz;
  logic [7:0][2:0]   cpos;
  logic [32:0]       rot_sat [3];
  logic signed [63:0] acc4, org4;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc4       = sm3_q[i][0] + sm3_q[i][1] + sm3_q[i][2];
      org4       = {{32{cfg_q[i][31]}}, cfg_q[i]};
      rot_sat[i] = sat32(org4 + ((acc4 + QHalf) >>> QUAT_FRAC_BITS));
      side4_d.rot[i] = rot_sat[i][31:0];
    end
    side4_d.sat  = sf3_q | rot_sat[0][32] | rot_sat[1][32] | rot_sat[2][32];
    side4_d.neg  = neg3_q;
    side4_d.zero = 1'b0;
    or_word = {1'b0, mag3_q[0] | mag3_q[1] | mag3_q[2] | mag3_q[3]};
    for (int c = 0; c < 8; c++) begin
      cnz[c]  = |or_word[8 * c +: 8];
      cpos[c] = '0;
      for (int b = 0; b < 8; b++) begin
        if (or_word[8 * c + b]) begin
          cpos[c] = 3'(b);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side4_q <= side4_d;
      for (int i = 0; i < 4; i++) begin
        mag4_q[i] <= mag3_q[i];
      end
      cnz4_q  <= cnz;
      cpos4_q <= cpos;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: leading-one position of the largest magnitude
  // ---------------------------------------------------------------------------
  logic           v5_q;
  rfc_pkg::side_t side5_q, side5_d;
  logic [62:0]    mag5_q [4];
  logic [5:0]     msb5_q;
  logic [5:0]     msb;

  always_comb begin
    msb = '0;
    for (int c = 0; c < 8; c++) begin
      if (cnz4_q[c]) begin
        msb = {3'(c), cpos4_q[c]};
      end
    end
    side5_d      = side4_q;
    side5_d.zero = ~|cnz4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side5_q <= side5_d;
      for (int i = 0; i < 4; i++) begin
        mag5_q[i] <= mag4_q[i];
      end
      msb5_q <= msb;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 6: common normalizing shift, right shifts truncate
  // ---------------------------------------------------------------------------
  localparam logic [5:0] NormMsb = 6'(rfc_pkg::NORM_MSB);

  logic             v6_q;
  rfc_pkg::side_t   side6_q;
  logic [3:0][30:0] mag6_q;
  logic [62:0]      shifted [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (msb5_q >= NormMsb) begin
        shifted[i] = mag5_q[i] >> (msb5_q - NormMsb);
      end else begin
        shifted[i] = mag5_q[i] << (NormMsb - msb5_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (en) begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side6_q <= side5_q;
      for (int i = 0; i < 4; i++) begin
        mag6_q[i] <= shifted[i][30:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stages 7 and 8: squares, then their sum
  // ---------------------------------------------------------------------------
  logic             v7_q, v8_q;
  rfc_pkg::side_t   side7_q, side8_q;
  logic [3:0][30:0] mag7_q, mag8_q;
  logic [61:0]      sq7_q [4];
  logic [63:0]      sum8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else if (en) begin
      v7_q <= v6_q;
      v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side7_q <= side6_q;
      mag7_q  <= mag6_q;
      for (int i = 0; i < 4; i++) begin
        sq7_q[i] <= 62'(mag6_q[i]) * 62'(mag6_q[i]);
      end
      side8_q <= side7_q;
      mag8_q  <= mag7_q;
      sum8_q  <= 64'(sq7_q[0]) + 64'(sq7_q[1]) + 64'(sq7_q[2]) + 64'(sq7_q[3]);
    end
  end

  // ---------------------------------------------------------------------------
  // integer square root, one result bit per stage
  // ---------------------------------------------------------------------------
  logic [63:0]      sqx_q [SqStages];
  logic [63:0]      sqr_q [SqStages];
  logic [3:0][30:0] sqm_q [SqStages];
  rfc_pkg::side_t   sqs_q [SqStages];
  logic             sqv_q [SqStages];

  for (genvar j = 0; j < SqStages; j++) begin : g_sqrt
    localparam logic [63:0] SqBit = 64'd1 << (62 - 2 * j);
    logic [63:0]      x_in, r_in, trial;
    logic [3:0][30:0] m_in;
    rfc_pkg::side_t   s_in;
    logic             v_in;

    if (j == 0) begin : g_head
      assign x_in = sum8_q;
      assign r_in = '0;
      assign m_in = mag8_q;
      assign s_in = side8_q;
      assign v_in = v8_q;
    end else begin : g_body
      assign x_in = sqx_q[j-1];
      assign r_in = sqr_q[j-1];
      assign m_in = sqm_q[j-1];
      assign s_in = sqs_q[j-1];
      assign v_in = sqv_q[j-1];
    end

    assign trial = r_in + SqBit;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sqv_q[j] <= 1'b0;
      end else if (en) begin
        sqv_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        if (x_in >= trial) begin
          sqx_q[j] <= x_in - trial;
          sqr_q[j] <= (r_in >> 1) + SqBit;
        end else begin
          sqx_q[j] <= x_in;
          sqr_q[j] <= r_in >> 1;
        end
        sqm_q[j] <= m_in;
        sqs_q[j] <= s_in;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // four restoring dividers: round_half_up(mag * 2^QFB / n), one bit per stage
  // ---------------------------------------------------------------------------
  logic [3:0][63:0]     drem_q [DivStages];
  logic [3:0][QuoW-1:0] dquo_q [DivStages];
  logic [31:0]          dn_q   [DivStages];
  rfc_pkg::side_t       ds_q   [DivStages];
  logic                 dv_q   [DivStages];

  for (genvar s = 0; s < DivStages; s++) begin : g_div
    localparam int unsigned Shift = QUAT_FRAC_BITS - s;
    logic [3:0][63:0]     rem_in, rem_out;
    logic [3:0][QuoW-1:0] quo_in, quo_out;
    logic [31:0]          n_in;
    rfc_pkg::side_t       s_in;
    logic                 v_in;
    logic [63:0]          dsr;

    if (s == 0) begin : g_head
      assign n_in = sqr_q[SqStages-1][31:0];
      assign s_in = sqs_q[SqStages-1];
      assign v_in = sqv_q[SqStages-1];
      for (genvar l = 0; l < 4; l++) begin : g_lane
        assign rem_in[l] = (64'(sqm_q[SqStages-1][l]) << QUAT_FRAC_BITS)
                         + 64'(n_in >> 1);
        assign quo_in[l] = '0;
      end
    end else begin : g_body
      assign n_in   = dn_q[s-1];
      assign s_in   = ds_q[s-1];
      assign v_in   = dv_q[s-1];
      assign rem_in = drem_q[s-1];
      assign quo_in = dquo_q[s-1];
    end

    assign dsr = 64'(n_in) << Shift;

    always_comb begin
      for (int l = 0; l < 4; l++) begin
        if (rem_in[l] >= dsr) begin
          rem_out[l] = rem_in[l] - dsr;
          quo_out[l] = {quo_in[l][QuoW-2:0], 1'b1};
        end else begin
          rem_out[l] = rem_in[l];
          quo_out[l] = {quo_in[l][QuoW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[s] <= 1'b0;
      end else if (en) begin
        dv_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        drem_q[s] <= rem_out;
        dquo_q[s] <= quo_out;
        dn_q[s]   <= n_in;
        ds_q[s]   <= s_in;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result word, output register and skid register
  // ---------------------------------------------------------------------------
  rfc_pkg::side_t   fin_side;
  logic             fin_v;
  logic [3:0][31:0] fin_q;
  rfc_pkg::out_t    fin_word, out_q, skid_q;
  logic             push, pop;

  assign fin_side = ds_q[DivStages-1];
  assign fin_v    = dv_q[DivStages-1];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      fin_q[l] = 32'(dquo_q[DivStages-1][l]);
      if (fin_side.zero) begin
        // zero product passes through unchanged
        fin_q[l] = '0;
      end else if (fin_side.neg[l]) begin
        fin_q[l] = -fin_q[l];
      end
    end
    fin_word.out_origin_x = fin_side.rot[0];
    fin_word.out_origin_y = fin_side.rot[1];
    fin_word.out_origin_z = fin_side.rot[2];
    fin_word.out_quat_w   = fin_q[0];
    fin_word.out_quat_x   = fin_q[1];
    fin_word.out_quat_y   = fin_q[2];
    fin_word.out_quat_z   = fin_q[3];
    fin_word.saturated    = fin_side.sat;
  end

  assign push = en & fin_v;
  assign pop  = out_v_q & out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      // pipe is frozen, drain the skid word first
      if (pop) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end
    end else if (!out_v_q || pop) begin
      out_v_q <= push;
    end else if (push) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (!out_v_q || pop) begin
      out_q <= fin_word;
    end else if (push) begin
      skid_q <= fin_word;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `RFC_ASSERT(a_skid_behind_out, skid_v_q |-> out_v_q, "skid holds a word with empty output")
  `RFC_ASSERT(a_out_from_pipe, $rose(out_v_q) |-> $past(fin_v), "output valid without a result")
  `RFC_ASSERT(a_quat_unit_range,
    out_v_q |-> ($signed(out_q.out_quat_w) <= 32'(QOne) &&
                 $signed(out_q.out_quat_w) >= 32'(-QOne)),
    "normalized quaternion out of range")

endmodule

/* dv/rfc_checker.sv */
// watches both channels and the apb port, predicts every composed pose and
// compares it with what comes out
module rfc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  rfc_in_if           in_m,
  rfc_out_if          out_m,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output int          errors,
  output int          pending
);

  localparam longint ONE_Q  = 64'sd1 <<< 30;
  localparam longint ONE_Q2 = 64'sd1 <<< 60;
  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint POS_MIN = -64'sd2147483648;

  logic [31:0]   parent_regs [rfc_pkg::NUM_CFG];
  rfc_pkg::out_t pose_queue [$];

  assign pending = pose_queue.size();

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // round half toward +inf
  function automatic longint round_up(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned x);
    longint unsigned res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > x) bit_w >>= 2;
    while (bit_w != 0) begin
      if (x >= res + bit_w) begin
        x -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  function automatic rfc_pkg::out_t compose_pose(rfc_pkg::in_t w);
    longint p[4], c[4], q[4], rm[9], wide[9], scl[3], org[3], chd[3], sc[3];
    longint unsigned mag[4], maxm, sum, n, r;
    longint acc, v;
    logic neg[4];
    logic clipped;
    rfc_pkg::out_t res;
    clipped = 1'b0;
    c[0] = longint'(w.child_quat_w);
    c[1] = longint'(w.child_quat_x);
    c[2] = longint'(w.child_quat_y);
    c[3] = longint'(w.child_quat_z);
    chd[0] = longint'(w.child_origin_x);
    chd[1] = longint'(w.child_origin_y);
    chd[2] = longint'(w.child_origin_z);
    sc[0] = longint'(w.scale_x);
    sc[1] = longint'(w.scale_y);
    sc[2] = longint'(w.scale_z);
    for (int i = 0; i < 4; i++) begin
      p[i] = clip(longint'($signed(parent_regs[3 + i])), -ONE_Q, ONE_Q);
      c[i] = clip(c[i], -ONE_Q, ONE_Q);
    end
    for (int i = 0; i < 3; i++) org[i] = longint'($signed(parent_regs[i]));
    // rotation matrix from the parent, exact then rounded and clamped
    wide[0] = ONE_Q2 - 2 * (p[2] * p[2] + p[3] * p[3]);
    wide[1] = 2 * (p[1] * p[2] + p[0] * p[3]);
    wide[2] = 2 * (p[1] * p[3] - p[0] * p[2]);
    wide[3] = 2 * (p[1] * p[2] - p[0] * p[3]);
    wide[4] = ONE_Q2 - 2 * (p[1] * p[1] + p[3] * p[3]);
    wide[5] = 2 * (p[2] * p[3] + p[0] * p[1]);
    wide[6] = 2 * (p[1] * p[3] + p[0] * p[2]);
    wide[7] = 2 * (p[2] * p[3] - p[0] * p[1]);
    wide[8] = ONE_Q2 - 2 * (p[1] * p[1] + p[2] * p[2]);
    for (int i = 0; i < 9; i++) rm[i] = clip(round_up(wide[i], 30), -ONE_Q, ONE_Q);
    for (int i = 0; i < 3; i++) begin
      v = round_up(chd[i] * sc[i], 16);
      scl[i] = clip(v, POS_MIN, POS_MAX);
      if (scl[i] != v) clipped = 1'b1;
    end
    for (int i = 0; i < 3; i++) begin
      acc = scl[0] * rm[i] + scl[1] * rm[3 + i] + scl[2] * rm[6 + i];
      v = org[i] + round_up(acc, 30);
      org[i] = clip(v, POS_MIN, POS_MAX);
      if (org[i] != v) clipped = 1'b1;
    end
    // hamilton product parent * child
    q[0] = p[0] * c[0] - p[1] * c[1] - p[2] * c[2] - p[3] * c[3];
    q[1] = p[1] * c[0] + p[0] * c[1] + p[2] * c[3] - p[3] * c[2];
    q[2] = p[0] * c[2] - p[1] * c[3] + p[2] * c[0] + p[3] * c[1];
    q[3] = p[1] * c[2] + p[0] * c[3] - p[2] * c[1] + p[3] * c[0];
    maxm = 0;
    for (int i = 0; i < 4; i++) begin
      neg[i] = q[i] < 0;
      mag[i] = neg[i] ? longint'(-q[i]) : longint'(q[i]);
      if (mag[i] > maxm) maxm = mag[i];
    end
    // zero product passes through as all zero
    if (maxm != 0) begin
      while (maxm >= (64'd1 << 31)) begin
        for (int i = 0; i < 4; i++) mag[i] >>= 1;
        maxm >>= 1;
      end
      while (maxm < (64'd1 << 30)) begin
        for (int i = 0; i < 4; i++) mag[i] <<= 1;
        maxm <<= 1;
      end
      sum = 0;
      for (int i = 0; i < 4; i++) sum += mag[i] * mag[i];
      n = floor_root(sum);
      for (int i = 0; i < 4; i++) begin
        r = (mag[i] * (64'd1 << 30) + (n >> 1)) / n;
        q[i] = neg[i] ? -longint'(r) : longint'(r);
      end
    end
    res.out_origin_x = org[0][31:0];
    res.out_origin_y = org[1][31:0];
    res.out_origin_z = org[2][31:0];
    res.out_quat_w   = q[0][31:0];
    res.out_quat_x   = q[1][31:0];
    res.out_quat_y   = q[2][31:0];
    res.out_quat_z   = q[3][31:0];
    res.saturated    = clipped;
    return res;
  endfunction

  task automatic compare_pose(rfc_pkg::out_t exp_w, rfc_pkg::out_t got_w);
    logic [31:0] ev[8], gv[8];
    string fname[8];
    fname = '{"out_origin_x", "out_origin_y", "out_origin_z", "out_quat_w",
              "out_quat_x", "out_quat_y", "out_quat_z", "saturated"};
    ev = '{exp_w.out_origin_x, exp_w.out_origin_y, exp_w.out_origin_z, exp_w.out_quat_w,
           exp_w.out_quat_x, exp_w.out_quat_y, exp_w.out_quat_z, 32'(exp_w.saturated)};
    gv = '{got_w.out_origin_x, got_w.out_origin_y, got_w.out_origin_z, got_w.out_quat_w,
           got_w.out_quat_x, got_w.out_quat_y, got_w.out_quat_z, 32'(got_w.saturated)};
    for (int i = 0; i < 8; i++) begin
      if (ev[i] !== gv[i]) begin
        $display("%0t: %s mismatch, expected %h actual %h", $time, fname[i], ev[i], gv[i]);
        errors++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rfc_pkg::NUM_CFG; i++) parent_regs[i] <= '0;
      parent_regs[rfc_pkg::CFG_QUAT_W] <= 32'h4000_0000;
    end else begin
      if (psel && penable && pwrite && pready && (paddr >> 2) < rfc_pkg::NUM_CFG)
        parent_regs[paddr >> 2] <= pwdata;
      if (in_m.valid && in_m.ready) pose_queue.push_back(compose_pose(in_m.data));
      if (out_m.valid && out_m.ready) begin
        if (pose_queue.size() == 0) begin
          $display("%0t: unexpected word, expected none actual %h", $time, out_m.data);
          errors++;
        end else begin
          compare_pose(pose_queue.pop_front(), out_m.data);
        end
      end
    end
  end

  initial errors = 0;
endmodule

/* dv/tb_rigid_frame_compose.sv */
// stimulus and verdict for the frame composer; checking lives in rfc_checker
module tb_rigid_frame_compose;

  localparam int DRAIN_CYCLES = 100;  // longer than the pipeline latency
  localparam int STALL_LIMIT  = 5000; // cycles without any word moving

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          errors, pending;
  bit          calm;       // no idling on either side in the last stretch
  int          quiet_cycles;

  rfc_in_if  in_ch ();
  rfc_out_if out_ch ();

  rigid_frame_compose DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  rfc_checker u_checker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_m    (in_ch),
    .out_m   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .pready  (pready),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // watchdog: any accepted word or register access counts as progress
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: ready drops in random bursts until the calm stretch
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19) - 1) @(negedge clk_i);
        @(negedge clk_i);
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(negedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic reg_write(rfc_pkg::cfg_reg_e idx, logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(idx) << 2;
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // write past the last register, must be ignored
  task automatic stray_write(logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= 5'(rfc_pkg::NUM_CFG) << 2;
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_parent(logic [31:0] ox, oy, oz, qw, qx, qy, qz);
    reg_write(rfc_pkg::CFG_ORIGIN_X, ox);
    reg_write(rfc_pkg::CFG_ORIGIN_Y, oy);
    reg_write(rfc_pkg::CFG_ORIGIN_Z, oz);
    reg_write(rfc_pkg::CFG_QUAT_W, qw);
    reg_write(rfc_pkg::CFG_QUAT_X, qx);
    reg_write(rfc_pkg::CFG_QUAT_Y, qy);
    reg_write(rfc_pkg::CFG_QUAT_Z, qz);
  endtask

  // stop offering words before the next edge can take the last one again
  task automatic hold_input();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
  endtask

  // let the pipeline empty before touching the registers
  task automatic drain();
    hold_input();
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // valid stays up across back-to-back words; one assignment per edge
  task automatic send_pose(rfc_pkg::in_t w);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  function automatic logic [31:0] pick_quat();
    case ($urandom_range(0, 9))
      0: return $urandom();                       // about half of them out of range, clamped
      1: return 32'h4000_0000;
      2: return 32'hC000_0000;
      3: return 32'h0;
      4: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_pos();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
      default: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(0, 5))
      0: return 32'h0001_0000;
      1: return 32'hFFFF_0000;
      2: return $urandom();
      default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  function automatic rfc_pkg::in_t random_pose();
    rfc_pkg::in_t w;
    w.child_origin_x = pick_pos();
    w.child_origin_y = pick_pos();
    w.child_origin_z = pick_pos();
    w.child_quat_w   = pick_quat();
    w.child_quat_x   = pick_quat();
    w.child_quat_y   = pick_quat();
    w.child_quat_z   = pick_quat();
    w.scale_x        = pick_scale();
    w.scale_y        = pick_scale();
    w.scale_z        = pick_scale();
    return w;
  endfunction

  function automatic rfc_pkg::in_t make_pose(logic [31:0] o, qw, qv, s);
    rfc_pkg::in_t w;
    w = '{o, o, o, qw, qv, qv, qv, s, s, s};
    return w;
  endfunction

  task automatic random_burst(int count);
    repeat (count) send_pose(random_pose());
  endtask

  initial begin
    calm         = 1'b0;
    quiet_cycles = 0;
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed words against the identity parent left by reset
    send_pose(make_pose(32'h0, 32'h4000_0000, 32'h0, 32'h0001_0000));
    send_pose(make_pose(32'h7FFF_FFFF, 32'h4000_0000, 32'h0, 32'h0001_0000));
    send_pose(make_pose(32'h8000_0000, 32'hC000_0000, 32'h0, 32'h0001_0000));
    // scaled component clips on both ends
    send_pose(make_pose(32'h8000_0000, 32'h4000_0000, 32'h0, 32'h8000_0000));
    send_pose(make_pose(32'h7FFF_FFFF, 32'h4000_0000, 32'h0, 32'h7FFF_FFFF));
    send_pose(make_pose(32'h7FFF_FFFF, 32'h4000_0000, 32'h0, 32'h8000_0000));
    // zero child gives a zero product
    send_pose(make_pose(32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000));
    // quaternion components beyond one are clamped
    send_pose(make_pose(32'h0001_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_0000));
    send_pose(make_pose(32'h0001_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_0000));
    send_pose(make_pose(32'hFFFF_FFFF, 32'h0, 32'h4000_0000, 32'h0));
    send_pose(make_pose(32'h0000_0001, 32'h0000_0001, 32'h0, 32'h0000_8000));
    send_pose(make_pose(32'h1234_5678, 32'h2D41_3CCD, 32'hD2BE_C333, 32'hFFFF_FFFF));
    drain();

    // parent with extreme origin and a half-turn quaternion
    load_parent(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h0, 32'h4000_0000, 32'h0, 32'h0);
    send_pose(make_pose(32'h7FFF_FFFF, 32'h4000_0000, 32'h0, 32'h0001_0000));
    send_pose(make_pose(32'h8000_0000, 32'h4000_0000, 32'h0, 32'h0001_0000));
    send_pose(make_pose(32'h0, 32'h0, 32'h0, 32'h0));
    random_burst(230);
    drain();

    // out-of-range parent quaternion, clamped and non-unit
    load_parent(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    stray_write(32'hFFFF_FFFF);
    random_burst(120);
    // hold off until every composed pose is back
    hold_input();
    while (pending != 0) @(negedge clk_i);
    random_burst(120);
    drain();

    // zero parent quaternion: every product is zero
    load_parent(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    random_burst(100);
    drain();

    // random parents, some of them unit-length-ish, some raw
    for (int k = 0; k < 4; k++) begin
      load_parent($urandom(), $urandom(), $urandom(),
                  pick_quat(), pick_quat(), pick_quat(), pick_quat());
      random_burst(170);
      drain();
    end

    // negative unit parent, last stretch with no idling
    load_parent(32'h0010_0000, 32'hFFF0_0000, 32'h0,
                32'hC000_0000, 32'h0, 32'h0, 32'h0);
    random_burst(80);
    calm = 1'b1;
    random_burst(200);
    hold_input();

    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
